// ===== design/vsac_pkg.sv =====
`default_nettype none

package vsac_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int INTERVAL_W    = 10;

    localparam logic [9:0]  FEVER_MARGIN    = 10'd5;
    localparam logic [6:0]  BEEP_BUZZER_MS  = 7'd100;
    localparam logic [6:0]  BEEP_ALL_MS     = 7'd80;
    localparam logic [INTERVAL_W-1:0] INTERVAL_INFO_MS   = 10'd1000;
    localparam logic [INTERVAL_W-1:0] INTERVAL_WARN_MS   = 10'd500;
    localparam logic [INTERVAL_W-1:0] INTERVAL_DANGER_MS = 10'd250;

    localparam logic [8:0]  HR_HIGH_RST   = 9'd100;
    localparam logic [8:0]  HR_LOW_RST    = 9'd60;
    localparam logic [6:0]  SPO2_LOW_RST  = 7'd90;
    localparam logic [9:0]  TEMP_HIGH_RST = 10'd375;
    localparam logic [5:0]  HR_HYST_RST   = 6'd5;
    localparam logic [4:0]  SPO2_HYST_RST = 5'd2;
    localparam logic [31:0] MUTE_TMO_RST  = 32'd60000;

    typedef enum logic [2:0] {
        OP_SAMPLE  = 3'd0,
        OP_FALL    = 3'd1,
        OP_CONFIRM = 3'd2,
        OP_MUTE    = 3'd3,
        OP_TICK    = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_NORMAL   = 3'd0,
        ST_HR_HIGH  = 3'd1,
        ST_HR_LOW   = 3'd2,
        ST_SPO2_LOW = 3'd3,
        ST_FEVER    = 3'd4,
        ST_FALL     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        LV_NONE    = 2'd0,
        LV_INFO    = 2'd1,
        LV_WARNING = 2'd2,
        LV_DANGER  = 2'd3
    } level_t;

    typedef enum logic [2:0] {
        MD_NONE      = 3'd0,
        MD_VISUAL    = 3'd1,
        MD_BUZZER    = 3'd2,
        MD_VIBRATION = 3'd3,
        MD_ALL       = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        LED_KEEP   = 3'd0,
        LED_NORMAL = 3'd1,
        LED_YELLOW = 3'd2,
        LED_RED    = 3'd3,
        LED_OFF    = 3'd4
    } led_t;

    typedef enum logic [1:0] {
        MOT_KEEP  = 2'd0,
        MOT_ON    = 2'd1,
        MOT_OFF   = 2'd2,
        MOT_PULSE = 2'd3
    } motor_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HR_HIGH_LIMIT   = 3'd0,
        CFG_HR_LOW_LIMIT    = 3'd1,
        CFG_SPO2_LOW_LIMIT  = 3'd2,
        CFG_TEMP_HIGH_LIMIT = 3'd3,
        CFG_HR_HYSTERESIS   = 3'd4,
        CFG_SPO2_HYSTERESIS = 3'd5,
        CFG_MUTE_TIMEOUT_MS = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [8:0]  hr_high_limit;
        logic [8:0]  hr_low_limit;
        logic [6:0]  spo2_low_limit;
        logic [9:0]  temp_high_limit;
        logic [5:0]  hr_hysteresis;
        logic [4:0]  spo2_hysteresis;
        logic [31:0] mute_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic hr_high;
        logic hr_low;
        logic spo2_low;
        logic fever;
    } alarm_latch_t;

    typedef struct packed {
        alarm_latch_t latch;
        status_t      status;
    } alarm_eval_t;

    function automatic level_t level_of(status_t st);
        level_t lv;
        case (st)
            ST_FALL, ST_SPO2_LOW: lv = LV_DANGER;
            ST_HR_HIGH, ST_HR_LOW: lv = LV_WARNING;
            ST_FEVER:             lv = LV_INFO;
            default:              lv = LV_NONE;
        endcase
        return lv;
    endfunction

    function automatic mode_t mode_of(level_t lv);
        mode_t md;
        case (lv)
            LV_INFO:    md = MD_VISUAL;
            LV_WARNING: md = MD_VIBRATION;
            LV_DANGER:  md = MD_ALL;
            default:    md = MD_NONE;
        endcase
        return md;
    endfunction

endpackage

`default_nettype wire

// ===== design/vsac_if.sv =====
`default_nettype none

interface vsac_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [8:0]  pulse_bpm;
    logic [6:0]  spo2;
    logic [9:0]  temperature;
    logic [31:0] now_ms;

    modport source (output valid, opcode, pulse_bpm, spo2, temperature, now_ms,
                    input ready);
    modport sink (input valid, opcode, pulse_bpm, spo2, temperature, now_ms,
                  output ready);
endinterface

interface vsac_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [1:0] level;
    logic [2:0] mode;
    logic       alarm_active;
    logic       alarm_muted;
    logic [2:0] led_cmd;
    logic [1:0] motor_cmd;
    logic [6:0] beep_ms;

    modport source (output valid, status, level, mode, alarm_active, alarm_muted,
                    led_cmd, motor_cmd, beep_ms, input ready);
    modport sink (input valid, status, level, mode, alarm_active, alarm_muted,
                  led_cmd, motor_cmd, beep_ms, output ready);
endinterface

`default_nettype wire

// ===== design/vital_sign_alarm_controller.sv =====
`default_nettype none

// Channel   Direction  Handshake       Payload
// in_ch     in         valid / ready   opcode, pulse_bpm, spo2, temperature, now_ms
// out_ch    out        valid / ready   status, level, mode, alarm_active, alarm_muted,
//                                      led_cmd, motor_cmd, beep_ms
// cfg       in         cfg_we          cfg_index, cfg_data (write only)
//
// One request per cycle sustained while out_ch.ready stays high; each request passes
// through the input register, then the result register.
// Latency is set by the input register and the result register around the alarm
// compare and state update logic.
// Reset: alert state, alarm latches and timers clear; config takes its defaults.
// A stalled result holds in the result register; in_ch.ready drops only when both
// registers are full and out_ch.ready is low.
module vital_sign_alarm_controller #(
    parameter int TIME_BITS = vsac_pkg::TIME_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    vsac_in_if.sink                               in_ch,
    vsac_out_if.source                            out_ch,
    input  wire logic                             cfg_we,
    input  wire logic [vsac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vsac_pkg::CFG_DATA_W-1:0]  cfg_data
);

    vsac_pkg::cfg_t cfg;

    vsac_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vsac_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

// ===== design/vsac_cfg_regs.sv =====
`default_nettype none

module vsac_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [vsac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vsac_pkg::CFG_DATA_W-1:0]   cfg_data,
    output vsac_pkg::cfg_t                         cfg
);

    vsac_pkg::cfg_t cfg_reg;
    vsac_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (vsac_pkg::cfg_index_t'(cfg_index))
                vsac_pkg::CFG_HR_HIGH_LIMIT:   cfg_next.hr_high_limit   = cfg_data[8:0];
                vsac_pkg::CFG_HR_LOW_LIMIT:    cfg_next.hr_low_limit    = cfg_data[8:0];
                vsac_pkg::CFG_SPO2_LOW_LIMIT:  cfg_next.spo2_low_limit  = cfg_data[6:0];
                vsac_pkg::CFG_TEMP_HIGH_LIMIT: cfg_next.temp_high_limit = cfg_data[9:0];
                vsac_pkg::CFG_HR_HYSTERESIS:   cfg_next.hr_hysteresis   = cfg_data[5:0];
                vsac_pkg::CFG_SPO2_HYSTERESIS: cfg_next.spo2_hysteresis = cfg_data[4:0];
                vsac_pkg::CFG_MUTE_TIMEOUT_MS: cfg_next.mute_timeout_ms = cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hr_high_limit   <= vsac_pkg::HR_HIGH_RST;
            cfg_reg.hr_low_limit    <= vsac_pkg::HR_LOW_RST;
            cfg_reg.spo2_low_limit  <= vsac_pkg::SPO2_LOW_RST;
            cfg_reg.temp_high_limit <= vsac_pkg::TEMP_HIGH_RST;
            cfg_reg.hr_hysteresis   <= vsac_pkg::HR_HYST_RST;
            cfg_reg.spo2_hysteresis <= vsac_pkg::SPO2_HYST_RST;
            cfg_reg.mute_timeout_ms <= vsac_pkg::MUTE_TMO_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/vsac_alarm_check.sv =====
`default_nettype none

// Four hysteresis alarms; the last one in order that is set gives the status.
module vsac_alarm_check (
    input  wire vsac_pkg::cfg_t         cfg,
    input  wire vsac_pkg::alarm_latch_t latch,
    input  wire logic [8:0]             pulse_bpm,
    input  wire logic [6:0]             spo2,
    input  wire logic [9:0]             temperature,
    output vsac_pkg::alarm_eval_t       eval
);

    logic hr_high_set;
    logic hr_high_clr;
    logic hr_low_set;
    logic hr_low_clr;
    logic spo2_set;
    logic spo2_clr;
    logic fever_set;
    logic fever_clr;

    assign hr_high_set = pulse_bpm > cfg.hr_high_limit;
    assign hr_high_clr = ({1'b0, pulse_bpm} + {4'b0, cfg.hr_hysteresis})
                         < {1'b0, cfg.hr_high_limit};

    assign hr_low_set  = (pulse_bpm != 9'd0) && (pulse_bpm < cfg.hr_low_limit);
    assign hr_low_clr  = {1'b0, pulse_bpm}
                         > ({1'b0, cfg.hr_low_limit} + {4'b0, cfg.hr_hysteresis});

    assign spo2_set    = (spo2 != 7'd0) && (spo2 < cfg.spo2_low_limit);
    assign spo2_clr    = {1'b0, spo2}
                         > ({1'b0, cfg.spo2_low_limit} + {3'b0, cfg.spo2_hysteresis});

    assign fever_set   = temperature > cfg.temp_high_limit;
    assign fever_clr   = ({1'b0, temperature} + {1'b0, vsac_pkg::FEVER_MARGIN})
                         < {1'b0, cfg.temp_high_limit};

    always_comb
    begin
        eval.latch.hr_high  = latch.hr_high  ? !hr_high_clr : hr_high_set;
        eval.latch.hr_low   = latch.hr_low   ? !hr_low_clr  : hr_low_set;
        eval.latch.spo2_low = latch.spo2_low ? !spo2_clr    : spo2_set;
        eval.latch.fever    = latch.fever    ? !fever_clr   : fever_set;

        if (eval.latch.fever)
            eval.status = vsac_pkg::ST_FEVER;
        else if (eval.latch.spo2_low)
            eval.status = vsac_pkg::ST_SPO2_LOW;
        else if (eval.latch.hr_low)
            eval.status = vsac_pkg::ST_HR_LOW;
        else if (eval.latch.hr_high)
            eval.status = vsac_pkg::ST_HR_HIGH;
        else
            eval.status = vsac_pkg::ST_NORMAL;
    end

endmodule

`default_nettype wire

// ===== design/vsac_ctrl.sv =====
`default_nettype none

module vsac_ctrl #(
    parameter int TIME_BITS = vsac_pkg::TIME_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire vsac_pkg::cfg_t cfg,
    vsac_in_if.sink             in_ch,
    vsac_out_if.source          out_ch
);

    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    // input register
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [2:0]             s1_opcode_reg;
    logic [8:0]             s1_hr_reg;
    logic [6:0]             s1_spo2_reg;
    logic [9:0]             s1_temp_reg;
    logic [31:0]            s1_now_reg;

    // alert state
    vsac_pkg::status_t      status_reg, status_next;
    vsac_pkg::level_t       level_reg, level_next;
    vsac_pkg::mode_t        mode_reg, mode_next;
    logic                   active_reg, active_next;
    logic                   muted_reg, muted_next;
    logic [TIME_BITS-1:0]   start_reg, start_next;
    logic [TIME_BITS-1:0]   anim_last_reg, anim_last_next;
    logic [1:0]             phase_reg, phase_next;
    vsac_pkg::alarm_latch_t latch_reg, latch_next;

    // result register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    vsac_pkg::status_t      out_status_reg;
    vsac_pkg::level_t       out_level_reg;
    vsac_pkg::mode_t        out_mode_reg;
    logic                   out_active_reg;
    logic                   out_muted_reg;
    vsac_pkg::led_t         out_led_reg;
    vsac_pkg::motor_t       out_motor_reg;
    logic [6:0]             out_beep_reg;

    logic                   in_accept;
    logic                   advance;
    vsac_pkg::alarm_eval_t  eval;
    logic [TIME_BITS-1:0]   now_w;
    logic [TIME_BITS-1:0]   mute_elapsed;
    logic [TIME_BITS-1:0]   anim_elapsed;
    logic [vsac_pkg::INTERVAL_W-1:0] interval;
    logic                   mute_lapsed;
    logic                   tick_due;
    logic                   raise;
    logic                   clear;
    vsac_pkg::status_t      raise_status;
    vsac_pkg::led_t         led;
    vsac_pkg::motor_t       motor;
    logic [6:0]             beep;
    logic                   even;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;
    assign in_accept = in_ch.valid && in_ch.ready;

    assign s1_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    vsac_alarm_check u_alarm_check (
        .cfg         (cfg),
        .latch       (latch_reg),
        .pulse_bpm   (s1_hr_reg),
        .spo2        (s1_spo2_reg),
        .temperature (s1_temp_reg),
        .eval        (eval)
    );

    assign now_w        = TIME_BITS'(s1_now_reg);
    assign mute_elapsed = now_w - start_reg;
    assign anim_elapsed = now_w - anim_last_reg;
    assign mute_lapsed  = CMP_W'(mute_elapsed) >= CMP_W'(cfg.mute_timeout_ms);
    assign tick_due     = anim_elapsed >= TIME_BITS'(interval);
    assign even         = !phase_reg[0];

    always_comb
    begin
        case (level_reg)
            vsac_pkg::LV_INFO:   interval = vsac_pkg::INTERVAL_INFO_MS;
            vsac_pkg::LV_DANGER: interval = vsac_pkg::INTERVAL_DANGER_MS;
            default:             interval = vsac_pkg::INTERVAL_WARN_MS;
        endcase
    end

    always_comb
    begin
        status_next    = status_reg;
        level_next     = level_reg;
        mode_next      = mode_reg;
        active_next    = active_reg;
        muted_next     = muted_reg;
        start_next     = start_reg;
        anim_last_next = anim_last_reg;
        phase_next     = phase_reg;
        latch_next     = latch_reg;
        led            = vsac_pkg::LED_KEEP;
        motor          = vsac_pkg::MOT_KEEP;
        beep           = '0;
        raise          = 1'b0;
        clear          = 1'b0;
        raise_status   = vsac_pkg::ST_NORMAL;

        case (vsac_pkg::opcode_t'(s1_opcode_reg))
            vsac_pkg::OP_SAMPLE:
            begin
                latch_next = eval.latch;
                if (muted_reg && mute_lapsed)
                    muted_next = 1'b0;
                if (eval.status != vsac_pkg::ST_NORMAL && eval.status != status_reg)
                begin
                    raise        = 1'b1;
                    raise_status = eval.status;
                end
                else if (eval.status == vsac_pkg::ST_NORMAL
                         && status_reg != vsac_pkg::ST_NORMAL)
                begin
                    clear = 1'b1;
                end
            end
            vsac_pkg::OP_FALL:
            begin
                raise        = 1'b1;
                raise_status = vsac_pkg::ST_FALL;
            end
            vsac_pkg::OP_CONFIRM:
            begin
                clear = 1'b1;
            end
            vsac_pkg::OP_MUTE:
            begin
                muted_next = 1'b1;
                start_next = now_w;
                motor      = vsac_pkg::MOT_OFF;
            end
            vsac_pkg::OP_TICK:
            begin
                if (active_reg && !muted_reg && tick_due)
                begin
                    anim_last_next = now_w;
                    phase_next     = phase_reg + 2'd1;
                    case (mode_reg)
                        vsac_pkg::MD_VISUAL:
                        begin
                            led = even ? vsac_pkg::LED_YELLOW : vsac_pkg::LED_OFF;
                        end
                        vsac_pkg::MD_BUZZER:
                        begin
                            if (even)
                                beep = vsac_pkg::BEEP_BUZZER_MS;
                        end
                        vsac_pkg::MD_VIBRATION:
                        begin
                            if (phase_reg == 2'd0)
                                motor = vsac_pkg::MOT_PULSE;
                        end
                        vsac_pkg::MD_ALL:
                        begin
                            if (even)
                            begin
                                led   = vsac_pkg::LED_RED;
                                motor = vsac_pkg::MOT_ON;
                                beep  = vsac_pkg::BEEP_ALL_MS;
                            end
                            else
                            begin
                                led   = vsac_pkg::LED_OFF;
                                motor = vsac_pkg::MOT_OFF;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase

        if (raise)
        begin
            status_next = raise_status;
            level_next  = vsac_pkg::level_of(raise_status);
            mode_next   = vsac_pkg::mode_of(level_next);
            active_next = 1'b1;
            start_next  = now_w;
            phase_next  = 2'd0;
            muted_next  = 1'b0;
        end

        if (clear)
        begin
            status_next = vsac_pkg::ST_NORMAL;
            level_next  = vsac_pkg::LV_NONE;
            mode_next   = vsac_pkg::MD_NONE;
            active_next = 1'b0;
            phase_next  = 2'd0;
            led         = vsac_pkg::LED_NORMAL;
            motor       = vsac_pkg::MOT_OFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= vsac_pkg::ST_NORMAL;
            level_reg     <= vsac_pkg::LV_NONE;
            mode_reg      <= vsac_pkg::MD_NONE;
            active_reg    <= 1'b0;
            muted_reg     <= 1'b0;
            start_reg     <= '0;
            anim_last_reg <= '0;
            phase_reg     <= 2'd0;
            latch_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                status_reg    <= status_next;
                level_reg     <= level_next;
                mode_reg      <= mode_next;
                active_reg    <= active_next;
                muted_reg     <= muted_next;
                start_reg     <= start_next;
                anim_last_reg <= anim_last_next;
                phase_reg     <= phase_next;
                latch_reg     <= latch_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_opcode_reg <= in_ch.opcode;
            s1_hr_reg     <= in_ch.pulse_bpm;
            s1_spo2_reg   <= in_ch.spo2;
            s1_temp_reg   <= in_ch.temperature;
            s1_now_reg    <= in_ch.now_ms;
        end
        if (advance)
        begin
            out_status_reg <= status_next;
            out_level_reg  <= level_next;
            out_mode_reg   <= mode_next;
            out_active_reg <= active_next;
            out_muted_reg  <= muted_next;
            out_led_reg    <= led;
            out_motor_reg  <= motor;
            out_beep_reg   <= beep;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.level        = out_level_reg;
    assign out_ch.mode         = out_mode_reg;
    assign out_ch.alarm_active = out_active_reg;
    assign out_ch.alarm_muted  = out_muted_reg;
    assign out_ch.led_cmd      = out_led_reg;
    assign out_ch.motor_cmd    = out_motor_reg;
    assign out_ch.beep_ms      = out_beep_reg;

    a_active_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg == (status_reg != vsac_pkg::ST_NORMAL))
        else $error("active flag out of step with status");

    a_level_mode_map: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg == vsac_pkg::level_of(status_reg)
        && mode_reg == vsac_pkg::mode_of(level_reg))
        else $error("level or mode does not follow status");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted request lost from input register");

    a_all_mode_beep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_beep_reg == vsac_pkg::BEEP_ALL_MS
        |-> out_led_reg == vsac_pkg::LED_RED && out_motor_reg == vsac_pkg::MOT_ON)
        else $error("all-mode beep without red LED and motor on");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
    import vsac_pkg::*;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [8:0]  pulse_bpm;
        logic [6:0]  spo2;
        logic [9:0]  temperature;
        logic [31:0] now_ms;
    } alarm_req_t;

    typedef struct packed {
        status_t    status;
        level_t     level;
        mode_t      mode;
        logic       active;
        logic       muted;
        led_t       led;
        motor_t     motor;
        logic [6:0] beep;
    } alarm_rpt_t;

    class alarm_shadow;
        cfg_t       cfg;
        status_t    cur_st;
        level_t     cur_lv;
        mode_t      cur_md;
        logic       active;
        logic       muted;
        logic [31:0] alert_start;
        logic [31:0] anim_last;
        logic [7:0] anim_step;
        logic       hr_high_lat;
        logic       hr_low_lat;
        logic       spo2_lat;
        logic       fever_lat;
        alarm_rpt_t due_reports[$];
        int         errors;

        function new();
            cfg.hr_high_limit   = HR_HIGH_RST;
            cfg.hr_low_limit    = HR_LOW_RST;
            cfg.spo2_low_limit  = SPO2_LOW_RST;
            cfg.temp_high_limit = TEMP_HIGH_RST;
            cfg.hr_hysteresis   = HR_HYST_RST;
            cfg.spo2_hysteresis = SPO2_HYST_RST;
            cfg.mute_timeout_ms = MUTE_TMO_RST;
            cur_st = ST_NORMAL;
            cur_lv = LV_NONE;
            cur_md = MD_NONE;
            active = 1'b0;
            muted = 1'b0;
            alert_start = '0;
            anim_last = '0;
            anim_step = '0;
            hr_high_lat = 1'b0;
            hr_low_lat = 1'b0;
            spo2_lat = 1'b0;
            fever_lat = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [31:0] d);
            case (idx)
                CFG_HR_HIGH_LIMIT:   cfg.hr_high_limit   = d[8:0];
                CFG_HR_LOW_LIMIT:    cfg.hr_low_limit    = d[8:0];
                CFG_SPO2_LOW_LIMIT:  cfg.spo2_low_limit  = d[6:0];
                CFG_TEMP_HIGH_LIMIT: cfg.temp_high_limit = d[9:0];
                CFG_HR_HYSTERESIS:   cfg.hr_hysteresis   = d[5:0];
                CFG_SPO2_HYSTERESIS: cfg.spo2_hysteresis = d[4:0];
                CFG_MUTE_TIMEOUT_MS: cfg.mute_timeout_ms = d;
                default: ;
            endcase
        endfunction

        function level_t severity(status_t st);
            case (st)
                ST_FALL, ST_SPO2_LOW:  return LV_DANGER;
                ST_HR_HIGH, ST_HR_LOW: return LV_WARNING;
                ST_FEVER:              return LV_INFO;
                default:               return LV_NONE;
            endcase
        endfunction

        function mode_t alert_mode(level_t lv);
            case (lv)
                LV_INFO:    return MD_VISUAL;
                LV_WARNING: return MD_VIBRATION;
                LV_DANGER:  return MD_ALL;
                default:    return MD_NONE;
            endcase
        endfunction

        function void sound(status_t st, logic [31:0] now);
            cur_st = st;
            cur_lv = severity(st);
            cur_md = alert_mode(cur_lv);
            active = 1'b1;
            alert_start = now;
            anim_step = '0;
            muted = 1'b0;
        endfunction

        function void silence();
            cur_st = ST_NORMAL;
            cur_lv = LV_NONE;
            cur_md = MD_NONE;
            active = 1'b0;
            anim_step = '0;
        endfunction

        function void note_request(alarm_req_t r);
            alarm_rpt_t  rpt;
            status_t     next_st;
            led_t        led;
            motor_t      mot;
            logic [6:0]  beep;
            logic [31:0] now;
            logic [31:0] elapsed;
            logic [31:0] ivl;
            logic        even;
            led = LED_KEEP;
            mot = MOT_KEEP;
            beep = '0;
            now = r.now_ms;
            case (r.opcode)
                OP_SAMPLE:
                begin
                    next_st = ST_NORMAL;
                    if (!hr_high_lat)
                    begin
                        if (r.pulse_bpm > cfg.hr_high_limit)
                        begin
                            hr_high_lat = 1'b1;
                            next_st = ST_HR_HIGH;
                        end
                    end
                    else if (int'(r.pulse_bpm) + int'(cfg.hr_hysteresis)
                             < int'(cfg.hr_high_limit))
                        hr_high_lat = 1'b0;
                    else
                        next_st = ST_HR_HIGH;

                    if (!hr_low_lat)
                    begin
                        if (r.pulse_bpm != 0 && r.pulse_bpm < cfg.hr_low_limit)
                        begin
                            hr_low_lat = 1'b1;
                            next_st = ST_HR_LOW;
                        end
                    end
                    else if (int'(r.pulse_bpm)
                             > int'(cfg.hr_low_limit) + int'(cfg.hr_hysteresis))
                        hr_low_lat = 1'b0;
                    else
                        next_st = ST_HR_LOW;

                    if (!spo2_lat)
                    begin
                        if (r.spo2 != 0 && r.spo2 < cfg.spo2_low_limit)
                        begin
                            spo2_lat = 1'b1;
                            next_st = ST_SPO2_LOW;
                        end
                    end
                    else if (int'(r.spo2)
                             > int'(cfg.spo2_low_limit) + int'(cfg.spo2_hysteresis))
                        spo2_lat = 1'b0;
                    else
                        next_st = ST_SPO2_LOW;

                    if (!fever_lat)
                    begin
                        if (r.temperature > cfg.temp_high_limit)
                        begin
                            fever_lat = 1'b1;
                            next_st = ST_FEVER;
                        end
                    end
                    else if (int'(r.temperature) + int'(FEVER_MARGIN)
                             < int'(cfg.temp_high_limit))
                        fever_lat = 1'b0;
                    else
                        next_st = ST_FEVER;

                    elapsed = now - alert_start;
                    if (muted && elapsed >= cfg.mute_timeout_ms)
                        muted = 1'b0;
                    if (next_st != ST_NORMAL && next_st != cur_st)
                        sound(next_st, now);
                    else if (next_st == ST_NORMAL && cur_st != ST_NORMAL)
                    begin
                        silence();
                        led = LED_NORMAL;
                        mot = MOT_OFF;
                    end
                end
                OP_FALL:
                    sound(ST_FALL, now);
                OP_CONFIRM:
                begin
                    silence();
                    led = LED_NORMAL;
                    mot = MOT_OFF;
                end
                OP_MUTE:
                begin
                    muted = 1'b1;
                    alert_start = now;
                    mot = MOT_OFF;
                end
                OP_TICK:
                begin
                    if (active && !muted)
                    begin
                        if (cur_lv == LV_INFO)
                            ivl = 32'(INTERVAL_INFO_MS);
                        else if (cur_lv == LV_DANGER)
                            ivl = 32'(INTERVAL_DANGER_MS);
                        else
                            ivl = 32'(INTERVAL_WARN_MS);
                        elapsed = now - anim_last;
                        if (elapsed >= ivl)
                        begin
                            even = ~anim_step[0];
                            anim_last = now;
                            case (cur_md)
                                MD_VISUAL:
                                    led = even ? LED_YELLOW : LED_OFF;
                                MD_BUZZER:
                                    if (even)
                                        beep = BEEP_BUZZER_MS;
                                MD_VIBRATION:
                                    if (anim_step[1:0] == 2'd0)
                                        mot = MOT_PULSE;
                                MD_ALL:
                                begin
                                    if (even)
                                    begin
                                        led = LED_RED;
                                        mot = MOT_ON;
                                        beep = BEEP_ALL_MS;
                                    end
                                    else
                                    begin
                                        led = LED_OFF;
                                        mot = MOT_OFF;
                                    end
                                end
                                default: ;
                            endcase
                            anim_step = anim_step + 8'd1;
                        end
                    end
                end
                default: ;
            endcase
            rpt.status = cur_st;
            rpt.level  = cur_lv;
            rpt.mode   = cur_md;
            rpt.active = active;
            rpt.muted  = muted;
            rpt.led    = led;
            rpt.motor  = mot;
            rpt.beep   = beep;
            due_reports.push_back(rpt);
        endfunction

        function string show(alarm_rpt_t r);
            return $sformatf("st=%0d lv=%0d md=%0d act=%0b mute=%0b led=%0d mot=%0d beep=%0d",
                             r.status, r.level, r.mode, r.active, r.muted,
                             r.led, r.motor, r.beep);
        endfunction

        function void check_result(alarm_rpt_t got);
            alarm_rpt_t want;
            if (due_reports.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unrequested report: %s", show(got));
                return;
            end
            want = due_reports.pop_front();
            if (got.status !== want.status || got.level !== want.level ||
                got.mode !== want.mode || got.active !== want.active ||
                got.muted !== want.muted || got.led !== want.led ||
                got.motor !== want.motor || got.beep !== want.beep)
            begin
                errors++;
                if (errors <= 10)
                    $display("report mismatch at %0t\n  exp %s\n  act %s",
                             $realtime, show(want), show(got));
            end
        endfunction

        function int pending();
            return due_reports.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vsac_in_if  in_ch();
    vsac_out_if out_ch();

    vital_sign_alarm_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    alarm_shadow sb = new();

    bit          calm = 1'b0;
    logic [31:0] clock_ms = '0;
    int unsigned pat_hr = 75;
    int unsigned pat_sp = 97;
    int unsigned pat_tp = 365;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        out_ch.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 15) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        alarm_rpt_t got;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.status = status_t'(out_ch.status);
            got.level  = level_t'(out_ch.level);
            got.mode   = mode_t'(out_ch.mode);
            got.active = out_ch.alarm_active;
            got.muted  = out_ch.alarm_muted;
            got.led    = led_t'(out_ch.led_cmd);
            got.motor  = motor_t'(out_ch.motor_cmd);
            got.beep   = out_ch.beep_ms;
            sb.check_result(got);
        end
    end

    function automatic int unsigned drift(int unsigned v, int unsigned span,
                                          int unsigned maxv);
        int s;
        s = int'(v) + int'($urandom_range(0, 2 * span)) - int'(span);
        if (s < 0)
            s = 0;
        if (s > int'(maxv))
            s = int'(maxv);
        return s;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue(alarm_req_t r);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= r.opcode;
        in_ch.pulse_bpm   <= r.pulse_bpm;
        in_ch.spo2        <= r.spo2;
        in_ch.temperature <= r.temperature;
        in_ch.now_ms      <= r.now_ms;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        sb.note_request(r);
        @(negedge clk);
    endtask

    task automatic send(logic [2:0] op, int unsigned hr, int unsigned sp,
                        int unsigned tp, logic [31:0] now);
        alarm_req_t r;
        r.opcode      = op;
        r.pulse_bpm   = hr[8:0];
        r.spo2        = sp[6:0];
        r.temperature = tp[9:0];
        r.now_ms      = now;
        issue(r);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        sb.write_reg(idx, d);
        @(negedge clk);
    endtask

    task automatic configure(int ph);
        cfg_index_t  reg_order[7] = '{CFG_HR_HIGH_LIMIT, CFG_HR_LOW_LIMIT,
                                      CFG_SPO2_LOW_LIMIT, CFG_TEMP_HIGH_LIMIT,
                                      CFG_HR_HYSTERESIS, CFG_SPO2_HYSTERESIS,
                                      CFG_MUTE_TIMEOUT_MS};
        logic [31:0] v[7];
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        case (ph)
            1:       v = '{511, 511, 127, 1023, 63, 31, 32'hFFFF_FFFF};
            2:       v = '{0, 0, 0, 0, 0, 0, 0};
            3:       v = '{3, 40, 20, 2, 63, 31, 700};
            default:
                v = '{$urandom_range(80, 140), $urandom_range(40, 70),
                      $urandom_range(80, 95), $urandom_range(360, 390),
                      $urandom_range(0, 15), $urandom_range(0, 5),
                      $urandom_range(200, 5000)};
        endcase
        for (int i = 0; i < 7; i++)
            write_reg(reg_order[i], v[i]);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_directed();
        send(OP_SAMPLE,  75,  98,  365,  0);
        send(OP_TICK,    75,  98,  365,  100);
        send(OP_SAMPLE,  511, 127, 1023, 200);
        send(OP_TICK,    0,   0,   0,    1300);
        send(OP_SAMPLE,  0,   0,   0,    1400);
        send(OP_SAMPLE,  30,  50,  370,  1500);
        send(OP_TICK,    0,   0,   0,    1800);
        send(OP_TICK,    0,   0,   0,    1900);
        send(OP_TICK,    0,   0,   0,    2100);
        // zero readings keep latched low alarms
        send(OP_SAMPLE,  0,   0,   370,  2200);
        send(OP_MUTE,    0,   0,   0,    2300);
        send(OP_TICK,    0,   0,   0,    3000);
        send(OP_FALL,    0,   0,   0,    3100);
        send(OP_TICK,    0,   0,   0,    3400);
        send(OP_SAMPLE,  80,  97,  370,  3500);
        send(OP_CONFIRM, 80,  97,  370,  3600);
        send(3'd5,       511, 127, 1023, 32'hFFFF_FFFF);
        send(3'd6,       511, 127, 1023, 32'hFFFF_FFFF);
        send(3'd7,       511, 127, 1023, 32'hFFFF_FFFF);
        send(OP_MUTE,    511, 127, 1023, 32'hFFFF_FF00);
        // mute lapses across the time wrap
        send(OP_SAMPLE,  0,   0,   0,    32'h000E_A000);
        send(OP_SAMPLE,  511, 127, 1023, 32'hFFFF_FFFF);
        send(OP_FALL,    0,   0,   0,    0);
        send(OP_CONFIRM, 0,   0,   0,    10);
    endtask

    task automatic run_random(int n);
        int          k;
        int unsigned op_pick;
        logic [2:0]  op;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(0, 400);
            op_pick = $urandom_range(0, 99);
            if (op_pick < 50)
                op = OP_SAMPLE;
            else if (op_pick < 80)
                op = OP_TICK;
            else if (op_pick < 85)
                op = OP_FALL;
            else if (op_pick < 90)
                op = OP_CONFIRM;
            else if (op_pick < 96)
                op = OP_MUTE;
            else
                op = 3'($urandom_range(5, 7));
            if (op == OP_SAMPLE)
            begin
                k = $urandom_range(0, 19);
                case (k)
                    0: pat_hr = 0;
                    1: pat_sp = 0;
                    2:
                    begin
                        pat_hr = $urandom_range(0, 511);
                        pat_sp = $urandom_range(0, 127);
                        pat_tp = $urandom_range(0, 1023);
                    end
                    3: pat_hr = drift(sb.cfg.hr_high_limit, sb.cfg.hr_hysteresis + 4, 511);
                    4: pat_hr = drift(sb.cfg.hr_low_limit, sb.cfg.hr_hysteresis + 4, 511);
                    5: pat_sp = drift(sb.cfg.spo2_low_limit, sb.cfg.spo2_hysteresis + 4, 127);
                    6: pat_tp = drift(sb.cfg.temp_high_limit, 9, 1023);
                    default:
                    begin
                        pat_hr = drift(pat_hr, 3, 511);
                        pat_sp = drift(pat_sp, 2, 127);
                        pat_tp = drift(pat_tp, 3, 1023);
                    end
                endcase
                send(op, pat_hr, pat_sp, pat_tp, clock_ms);
            end
            else
                send(op, $urandom, $urandom, $urandom, clock_ms);
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.opcode      = '0;
        in_ch.pulse_bpm   = '0;
        in_ch.spo2        = '0;
        in_ch.temperature = '0;
        in_ch.now_ms      = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        run_directed();
        clock_ms = 32'd5000;
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
                configure(ph);
            if (ph == 3)
                clock_ms = 32'hFFFF_0000;
            calm = (ph == 5);
            run_random(240);
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
